/* rtl/core/aitu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aitu_pkg;

    localparam int TimeW    = 63;
    localparam int IvW      = 32;
    localparam int InDataW  = 96;
    localparam int InUserW  = 3;
    localparam int OutDataW = 96;
    localparam int OutUserW = 2;
    localparam int PaddrW   = 3;
    localparam int PdataW   = 32;

    localparam logic [IvW-1:0] MinIvRst = 32'd1000;
    localparam logic [IvW-1:0] MaxIvRst = 32'd50000000;

    typedef enum logic [1:0] {
        CMD_SET_ALARM = 2'd0,
        CMD_GET_TIME  = 2'd1,
        CMD_SET_RT    = 2'd2,
        CMD_EXPIRY    = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_MIN_IV = 1'b0,
        REG_MAX_IV = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [IvW-1:0] min_iv;
        logic [IvW-1:0] max_iv;
    } t_cfg;

    // value holds the delay, raised to the minimum interval if shorter, for set alarm, the raw value otherwise
    typedef struct packed {
        t_cmd             cmd;
        logic [TimeW-1:0] value;
        logic             clock_sel;
        logic [IvW-1:0]   remaining;
    } t_item;

endpackage

`default_nettype wire

/* rtl/core/aitu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module aitu_front (
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire  [aitu_pkg::InDataW-1:0]  i_s_axis_tdata,
    input  wire  [aitu_pkg::InUserW-1:0]  i_s_axis_tuser,
    input  aitu_pkg::t_cfg                i_cfg,
    input  wire                           i_q_full,
    output logic                          o_push,
    output aitu_pkg::t_item               o_item
);
    import aitu_pkg::*;

    logic [TimeW-1:0] w_value;
    t_cmd             w_cmd;

    assign w_cmd   = t_cmd'(i_s_axis_tuser[1:0]);
    assign w_value = i_s_axis_tdata[TimeW-1:0];

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_item.cmd       = w_cmd;
        o_item.clock_sel = i_s_axis_tuser[2];
        o_item.remaining = i_s_axis_tdata[TimeW+IvW-1:TimeW];
        o_item.value     = w_value;
        // short delays are raised to the minimum load
        if (w_cmd == CMD_SET_ALARM && w_value < {{(TimeW-IvW){1'b0}}, i_cfg.min_iv}) begin
            o_item.value = {{(TimeW-IvW){1'b0}}, i_cfg.min_iv};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aitu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module aitu_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  aitu_pkg::t_item  i_item,
    output logic             o_full,
    output logic             o_valid,
    input  wire              i_pop,
    output aitu_pkg::t_item  o_item
);
    import aitu_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aitu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module aitu_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  aitu_pkg::t_cfg                i_cfg,
    input  wire                           i_q_valid,
    input  aitu_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    output logic [aitu_pkg::OutDataW-1:0] o_m_axis_tdata,
    output logic [aitu_pkg::OutUserW-1:0] o_m_axis_tuser
);
    import aitu_pkg::*;

    localparam int PadW = TimeW - IvW;

    logic [TimeW-1:0] r_rt, n_rt;
    logic [TimeW-1:0] r_mono, n_mono;
    logic [TimeW-1:0] r_delay, n_delay;
    logic [IvW-1:0]   r_last, n_last;
    logic             r_armed, n_armed;

    logic             r_out_valid;
    logic [TimeW-1:0] r_time, n_time;
    logic [IvW-1:0]   r_load, n_load;
    logic             r_strobe, n_strobe;
    logic             r_fired, n_fired;

    logic [IvW-1:0]   w_elapsed;
    logic [TimeW-1:0] w_dec;
    logic [TimeW-1:0] w_last_ext;
    logic [TimeW-1:0] w_min_ext;
    logic [TimeW-1:0] w_max_ext;

    assign o_pop = i_q_valid && (!r_out_valid || i_m_axis_tready);

    assign w_last_ext = {{PadW{1'b0}}, r_last};
    assign w_min_ext  = {{PadW{1'b0}}, i_cfg.min_iv};
    assign w_max_ext  = {{PadW{1'b0}}, i_cfg.max_iv};
    assign w_elapsed  = (i_item.remaining > r_last) ? '0 : (r_last - i_item.remaining);
    assign w_dec      = (r_delay > w_last_ext) ? (r_delay - w_last_ext) : '0;

    always_comb begin
        n_rt     = r_rt;
        n_mono   = r_mono;
        n_delay  = r_delay;
        n_last   = r_last;
        n_armed  = r_armed;
        n_time   = '0;
        n_load   = '0;
        n_strobe = 1'b0;
        n_fired  = 1'b0;
        unique case (i_item.cmd)
            CMD_SET_ALARM: begin
                n_rt     = r_rt + {{PadW{1'b0}}, w_elapsed};
                n_delay  = i_item.value;
                n_armed  = 1'b1;
                n_last   = (i_item.value > w_max_ext) ? i_cfg.max_iv : i_item.value[IvW-1:0];
                n_strobe = 1'b1;
                n_load   = n_last;
            end
            CMD_GET_TIME: begin
                n_time = (i_item.clock_sel ? r_mono : r_rt) + {{PadW{1'b0}}, w_elapsed};
            end
            CMD_SET_RT: begin
                n_rt = i_item.value;
                if (r_armed) begin
                    n_fired = 1'b1;
                    n_armed = 1'b0;
                end
            end
            CMD_EXPIRY: begin
                n_rt     = r_rt + w_last_ext;
                n_mono   = r_mono + w_last_ext;
                n_delay  = w_dec;
                n_strobe = 1'b1;
                if (w_dec <= {1'b0, w_min_ext[TimeW-1:1]}) begin
                    n_delay = w_max_ext;
                    n_last  = i_cfg.max_iv;
                    if (r_armed) begin
                        n_fired = 1'b1;
                        n_armed = 1'b0;
                    end
                end else if (w_dec < w_min_ext) begin
                    n_last = i_cfg.min_iv;
                end else if (w_dec < w_max_ext) begin
                    n_last = w_dec[IvW-1:0];
                end else begin
                    n_last = i_cfg.max_iv;
                end
                n_load = n_last;
            end
            default: begin
                n_time = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt        <= '0;
            r_mono      <= '0;
            r_delay     <= {{PadW{1'b0}}, MaxIvRst};
            r_last      <= MaxIvRst;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rt        <= n_rt;
                r_mono      <= n_mono;
                r_delay     <= n_delay;
                r_last      <= n_last;
                r_armed     <= n_armed;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_time   <= n_time;
            r_load   <= n_load;
            r_strobe <= n_strobe;
            r_fired  <= n_fired;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OutDataW-TimeW-IvW){1'b0}}, r_load, r_time};
    assign o_m_axis_tuser  = {r_fired, r_strobe};

endmodule

`default_nettype wire

/* rtl/core/alarm_interval_timer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// path: an accepted input transaction is written into the queue, and the back end then
// pops it and writes the state update into the output register when that can accept
// throughput: one transaction per cycle unless the output stalls (back-end state update)
// a two-entry queue and an output register let both sides stall independently
// reset (i_rst_n low, synchronous): clocks cleared, alarm disarmed, delay and last load
// set to the reset max interval, queue and output emptied, intervals to 1000 and 50000000
module alarm_interval_timer_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // value[62:0], remaining[94:63], zero pad
    input  wire  [aitu_pkg::InDataW-1:0]  i_s_axis_tdata,
    // cmd[1:0], clock_sel[2]
    input  wire  [aitu_pkg::InUserW-1:0]  i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // time_out[62:0], load_interval[94:63], zero pad
    output logic [aitu_pkg::OutDataW-1:0] o_m_axis_tdata,
    // load_strobe[0], alarm_fired[1]
    output logic [aitu_pkg::OutUserW-1:0] o_m_axis_tuser,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [aitu_pkg::PaddrW-1:0]   paddr,
    input  wire  [aitu_pkg::PdataW-1:0]   pwdata,
    output logic [aitu_pkg::PdataW-1:0]   prdata,
    output logic                          pready
);
    import aitu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_push;
    logic     w_full;
    logic     w_q_valid;
    logic     w_pop;
    t_item    w_in_item;
    t_item    w_q_item;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_iv <= MinIvRst;
            r_cfg.max_iv <= MaxIvRst;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MIN_IV: r_cfg.min_iv <= pwdata;
                REG_MAX_IV: r_cfg.max_iv <= pwdata;
                default:    r_cfg.min_iv <= r_cfg.min_iv;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MIN_IV: prdata = r_cfg.min_iv;
            REG_MAX_IV: prdata = r_cfg.max_iv;
            default:    prdata = '0;
        endcase
    end

    aitu_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg           (r_cfg),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_item          (w_in_item)
    );

    aitu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    aitu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
